// ===== sv/msaa_sample_pattern_registers_unit_assert.svh =====
// assertion macros for the sample pattern register unit
// taken by the files that check their own sequencing; needs nothing else

`ifndef MSAA_SAMPLE_PATTERN_REGISTERS_UNIT_ASSERT_SVH
`define MSAA_SAMPLE_PATTERN_REGISTERS_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MSPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MSPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/msps_pkg.sv =====
// shared constants, types and helpers of the sample pattern register unit
// no dependencies
`default_nettype none

package msps_pkg;

  localparam int MAX_SAMPLES   = 16;
  localparam int QUAD_PIXELS   = 4;
  localparam int STORE_DEPTH   = QUAD_PIXELS * MAX_SAMPLES;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);
  localparam int SAMPLE_W      = $clog2(MAX_SAMPLES);
  localparam int CENTROID_W    = 4 * MAX_SAMPLES;

  localparam logic [4:0] CENTROID_WORD1 = 5'd1;
  localparam logic [4:0] FIRST_LOC_WORD = 5'd2;
  localparam logic [4:0] MAX_DIST_WORD  = 5'd18;

  // commands from the sequencer to the priority unit
  typedef struct packed {
    logic                load;
    logic [SAMPLE_W-1:0] load_idx;
    logic [7:0]          load_loc;
    logic                start;
    logic [SAMPLE_W-1:0] mask;
  } prio_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } prio_stat_t;

  // magnitude of a signed nibble, -8 gives 8
  function automatic logic [3:0] nib_abs(input logic [3:0] v);
    logic [3:0] r;
    r = v[3] ? 4'(~v + 4'd1) : v;
    return r;
  endfunction

  function automatic logic [6:0] nib_sq(input logic [3:0] v);
    logic [3:0] a;
    logic [7:0] p;
    a = nib_abs(v);
    p = {4'b0, a} * {4'b0, a};
    return p[6:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/msps_if.sv =====
// handshake channels of the sample pattern register unit: locations in, words out
// depends on nothing but the field widths of the item formats
`default_nettype none

interface msps_loc_if;
  logic              valid;
  logic              ready;
  logic [1:0]        pixel;
  logic [3:0]        sample;
  logic signed [3:0] loc_x;
  logic signed [3:0] loc_y;
  logic              final_item;

  modport source (output valid, pixel, sample, loc_x, loc_y, final_item, input ready);
  modport sink   (input valid, pixel, sample, loc_x, loc_y, final_item, output ready);
endinterface

interface msps_word_if;
  logic        valid;
  logic        ready;
  logic [4:0]  word_index;
  logic [31:0] word_value;
  logic        last_word;

  modport source (output valid, word_index, word_value, last_word, input ready);
  modport sink   (input valid, word_index, word_value, last_word, output ready);
endinterface

`default_nettype wire

// ===== sv/msps_prio.sv =====
// centroid priority unit: squared distances of the top-left pixel's samples
// and a selection sort on one shared comparator; uses msps_pkg
`default_nettype none

module msps_prio import msps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire prio_cmd_t             cmd,
  output prio_stat_t                 stat,
  output logic [CENTROID_W-1:0]      centroid
);

  logic [7:0]            sq_dist [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] taken;
  logic [SAMPLE_W-1:0]   i_cnt;
  logic [SAMPLE_W-1:0]   j_cnt;
  logic [SAMPLE_W-1:0]   mask;
  logic [SAMPLE_W-1:0]   best_idx;
  logic [7:0]            best_val;
  logic                  found;
  logic                  busy;
  logic                  done;

  logic [7:0]            cand;
  logic                  take;
  logic [SAMPLE_W-1:0]   best_idx_next;
  logic [7:0]            best_val_next;
  logic                  commit;

  assign cand          = sq_dist[j_cnt];
  assign take          = !taken[j_cnt] && (!found || cand < best_val);
  assign best_idx_next = take ? j_cnt : best_idx;
  assign best_val_next = take ? cand : best_val;
  assign commit        = busy && !cmd.start && (j_cnt == mask);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_dist[cmd.load_idx] <= {1'b0, nib_sq(cmd.load_loc[3:0])} +
                               {1'b0, nib_sq(cmd.load_loc[7:4])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= commit && (i_cnt == mask);
      if (cmd.start) begin
        busy  <= 1'b1;
        i_cnt <= '0;
        j_cnt <= '0;
        found <= 1'b0;
        taken <= '0;
        mask  <= cmd.mask;
      end else if (busy) begin
        if (j_cnt == mask) begin
          taken[best_idx_next] <= 1'b1;
          found <= 1'b0;
          j_cnt <= '0;
          if (i_cnt == mask) begin
            busy <= 1'b0;
          end else begin
            i_cnt <= i_cnt + 1'b1;
          end
        end else begin
          j_cnt    <= j_cnt + 1'b1;
          found    <= found | take;
          best_idx <= best_idx_next;
          best_val <= best_val_next;
        end
      end
    end
  end

  // fields whose index wraps onto this rank get the winner as well
  always_ff @(posedge clk) begin
    if (commit) begin
      for (int k = 0; k < MAX_SAMPLES; k++) begin
        if ((SAMPLE_W'(k) & mask) == i_cnt) begin
          centroid[4*k +: 4] <= best_idx_next;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== sv/msaa_sample_pattern_registers_unit.sv =====
// Sample pattern register unit for a 2x2 quad. An item without final_item is
// stored in the location store. A final item starts the word run: the top-left
// pixel's n locations are read and their distances squared, the selection sort
// runs on the single comparator of msps_prio, then 19 words go out, each
// location word reading four locations on the one read port of the location store.
// No new item is taken until the word run ends.
// Depends on msps_pkg, msps_if and msps_prio.
`default_nettype none

module msaa_sample_pattern_registers_unit import msps_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data,
  msps_loc_if.sink        samples,
  msps_word_if.source     words
);

`include "msaa_sample_pattern_registers_unit_assert.svh"

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIST_RD = 3'd1;
  localparam logic [2:0] S_DIST_WR = 3'd2;
  localparam logic [2:0] S_SORT    = 3'd3;
  localparam logic [2:0] S_PUT     = 3'd4;
  localparam logic [2:0] S_LOC_RD  = 3'd5;
  localparam logic [2:0] S_LOC_WR  = 3'd6;

  logic [2:0]            state;
  logic [2:0]            log2_samples;
  logic [SAMPLE_W-1:0]   mask;
  logic [SAMPLE_W-1:0]   cnt;
  logic [4:0]            word;
  logic [1:0]            sub;
  logic [31:0]           acc;
  logic [3:0]            dmax;

  logic [7:0]            store [STORE_DEPTH];
  logic [7:0]            rd_q;
  logic [STORE_AW-1:0]   rd_addr;

  logic                  o_valid;
  logic [4:0]            o_index;
  logic [31:0]           o_value;
  logic                  o_last;

  prio_cmd_t             pcmd;
  prio_stat_t            pstat;
  logic [CENTROID_W-1:0] centroid;

  logic                  in_acc;
  logic                  out_free;
  logic [2:0]            lg_eff;
  logic [SAMPLE_W-1:0]   mask_cfg;
  logic [4:0]            word_m2;
  logic [SAMPLE_W-1:0]   cur_sample;
  logic                  in_use;
  logic [3:0]            ax;
  logic [3:0]            ay;
  logic [3:0]            dmax_next;
  logic [31:0]           put_value;

  assign in_acc   = samples.valid && samples.ready;
  assign out_free = !o_valid || words.ready;
  assign lg_eff   = (log2_samples > 3'd4) ? 3'd4 : log2_samples;
  assign mask_cfg = SAMPLE_W'((5'd1 << lg_eff) - 5'd1);
  assign word_m2  = word - FIRST_LOC_WORD;
  assign cur_sample = {word_m2[1:0], sub};
  assign in_use   = cur_sample <= mask;

  assign ax = nib_abs(rd_q[3:0]);
  assign ay = nib_abs(rd_q[7:4]);
  always_comb begin
    dmax_next = dmax;
    if (ax > dmax_next) dmax_next = ax;
    if (ay > dmax_next) dmax_next = ay;
  end

  always_comb begin
    case (state)
      S_DIST_RD: rd_addr = {2'b00, cnt};
      S_LOC_RD:  rd_addr = {word_m2[3:2], cur_sample};
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    if (word == '0) begin
      put_value = centroid[31:0];
    end else if (word == CENTROID_WORD1) begin
      put_value = centroid[63:32];
    end else if (word == MAX_DIST_WORD) begin
      put_value = {28'b0, dmax};
    end else begin
      put_value = acc;
    end
  end

  assign pcmd.load     = (state == S_DIST_WR);
  assign pcmd.load_idx = cnt;
  assign pcmd.load_loc = rd_q;
  assign pcmd.start    = (state == S_DIST_WR) && (cnt == mask);
  assign pcmd.mask     = mask;

  msps_prio u_prio (
    .clk      (clk),
    .rst      (rst),
    .cmd      (pcmd),
    .stat     (pstat),
    .centroid (centroid)
  );

  // location store, y nibble high
  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[{samples.pixel, samples.sample}] <= {samples.loc_y, samples.loc_x};
    end
    rd_q <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_samples <= '0;
    end else if (cfg_wr_en) begin
      log2_samples <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      dmax    <= '0;
    end else begin
      // in the put state the output register stays full either way
      if (words.ready && state != S_PUT) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc && samples.final_item) begin
            mask  <= mask_cfg;
            cnt   <= '0;
            dmax  <= '0;
            state <= S_DIST_RD;
          end
        end
        S_DIST_RD: begin
          state <= S_DIST_WR;
        end
        S_DIST_WR: begin
          if (cnt == mask) begin
            state <= S_SORT;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_DIST_RD;
          end
        end
        S_SORT: begin
          if (pstat.done) begin
            word  <= '0;
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_index <= word;
            o_value <= put_value;
            o_last  <= (word == MAX_DIST_WORD);
            if (word == MAX_DIST_WORD) begin
              state <= S_IDLE;
            end else begin
              word <= word + 1'b1;
              if (word != '0 && word != MAX_DIST_WORD - 5'd1) begin
                sub   <= '0;
                acc   <= '0;
                state <= S_LOC_RD;
              end
            end
          end
        end
        S_LOC_RD: begin
          state <= S_LOC_WR;
        end
        S_LOC_WR: begin
          if (in_use) begin
            acc[8*sub +: 8] <= rd_q;
            dmax            <= dmax_next;
          end
          if (sub == 2'd3) begin
            state <= S_PUT;
          end else begin
            sub   <= sub + 1'b1;
            state <= S_LOC_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign samples.ready    = (state == S_IDLE);
  assign words.valid      = o_valid;
  assign words.word_index = o_index;
  assign words.word_value = o_value;
  assign words.last_word  = o_last;

  `MSPS_ASSERT_IMP(a_last_is_max, clk, rst, o_valid && o_last, o_index == MAX_DIST_WORD, "last word is not the distance word")
  `MSPS_ASSERT_IMP(a_sort_owned, clk, rst, state != S_SORT, !pstat.busy, "priority unit busy outside the sort")
  `MSPS_ASSERT_NXT(a_final_starts, clk, rst, in_acc && samples.final_item, state == S_DIST_RD, "final item did not start the run")
  `MSPS_ASSERT_NXT(a_put_loads, clk, rst, state == S_PUT && out_free, o_valid && o_index == $past(word), "word not loaded when output free")

endmodule

`default_nettype wire
